[hdl/rch_pkg.sv]
// Shared types and constants of the region colour histogram engine.
`default_nettype none

package rch_pkg;

    localparam int WORD_W   = 24;
    localparam int REGION_W = 10;
    localparam int PIXEL_W  = 8;
    localparam int SIM_W    = 17;
    localparam int DIV_W    = 35;
    localparam int QUO_W    = 25;
    localparam int STEP_W   = 5;
    localparam int PROD_W   = 49;

    localparam logic [WORD_W-1:0] WORD_MAX = {WORD_W{1'b1}};
    localparam logic [SIM_W-1:0]  Q16_ONE  = SIM_W'(65536);

    localparam logic [STEP_W-1:0] NORM_STEPS  = STEP_W'(17);
    localparam logic [STEP_W-1:0] MERGE_STEPS = STEP_W'(25);

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_NORM  = 2'd1,
        CMD_SIM   = 2'd2,
        CMD_MERGE = 2'd3
    } command_t;

    typedef struct packed {
        command_t              command;
        logic [REGION_W-1:0]   region_a;
        logic [REGION_W-1:0]   region_b;
        logic [PIXEL_W-1:0]    pixel_red;
        logic [PIXEL_W-1:0]    pixel_green;
        logic [PIXEL_W-1:0]    pixel_blue;
        logic [WORD_W-1:0]     size_a;
        logic [WORD_W-1:0]     size_b;
    } in_item_t;

    typedef struct packed {
        logic [SIM_W-1:0] similarity;
        logic             error;
    } out_item_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  divisor;
        logic [DIV_W-1:0]  rem_init;
        logic [QUO_W-1:0]  bits;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

[hdl/rch_stream_if.sv]
// Valid/ready channel carrying one item of a given payload type.
`default_nettype none

interface rch_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hdl/rch_mem.sv]
// Histogram bin store: one write port and one registered read port.
`default_nettype none

module rch_mem #(
    parameter int DEPTH  = 76800,
    parameter int ADDR_W = 17
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [rch_pkg::WORD_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [rch_pkg::WORD_W-1:0] rd_data
);
    import rch_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hdl/rch_div.sv]
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module rch_div (
    input  logic              clk,
    input  logic              rst_n,
    input  rch_pkg::div_req_t req,
    output rch_pkg::div_rsp_t rsp
);
    import rch_pkg::*;

    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  div_reg;
    logic [QUO_W-1:0]  bits_reg;
    logic [QUO_W-1:0]  q_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIV_W:0] shifted;
    logic [DIV_W:0] diff;
    logic           ge;

    always_comb
    begin
        shifted = {rem_reg, bits_reg[QUO_W-1]};
        diff    = shifted - {1'b0, div_reg};
        ge      = shifted >= {1'b0, div_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= req.steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.rem_init;
            div_reg  <= req.divisor;
            bits_reg <= req.bits;
            q_reg    <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            bits_reg <= {bits_reg[QUO_W-2:0], 1'b0};
            q_reg    <= {q_reg[QUO_W-2:0], ge};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

`default_nettype wire

[hdl/region_color_histogram_engine.sv]
// Top level: command sequencer around the bin store, multiplier and divider.
//
//  channel | dir | payload                                        | handshake
//  in_ch   | in  | command, regions, pixel channels, region sizes | valid/ready
//  out_ch  | out | similarity, error                              | valid/ready
//
// After reset a clearing pass writes zeros to all min(MAX_REGIONS,1024)*BINS*CHANNELS
// words, one a cycle, before the first item is taken. Add pixel reads and writes one bin
// per channel; normalize, similarity and merge walk all BINS*CHANNELS bins through the
// single read port of the bin store, and normalize and merge divide each bin bit-serially.
// One item is worked on at a time; a stalled result holds the next one in the done state.
`default_nettype none

module region_color_histogram_engine #(
    parameter int MAX_REGIONS = 1024,
    parameter int BINS        = 25,
    parameter int CHANNELS    = 3
) (
    input  logic         clk,
    input  logic         rst_n,
    rch_stream_if.sink   in_ch,
    rch_stream_if.source out_ch
);
    import rch_pkg::*;

    localparam int HIST_LEN     = BINS * CHANNELS;
    localparam int REGIONS_USED = (MAX_REGIONS < 1024) ? MAX_REGIONS : 1024;
    localparam int DEPTH        = REGIONS_USED * HIST_LEN;
    localparam int ADDR_W       = $clog2(DEPTH);
    localparam int IDX_W        = $clog2(HIST_LEN + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HIST_LEN - 1);
    localparam logic [IDX_W-1:0] OFF_LAST = IDX_W'((CHANNELS - 1) * BINS);
    localparam logic [IDX_W-1:0] OFF_STEP = IDX_W'(BINS);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_ADD_RD, ST_ADD_WR,
        ST_NSUM_RD, ST_NSUM_ACC, ST_NCHK, ST_NDIV_RD, ST_NDIV_LD, ST_NDIV_RUN,
        ST_SIM_RDA, ST_SIM_RDB, ST_SIM_ACC, ST_SIM_END,
        ST_M_RDA, ST_M_RDB, ST_M_MUL1, ST_M_MUL2, ST_M_DLD, ST_M_DIV, ST_M_WRB,
        ST_DONE
    } state_t;

    in_item_t  in_item;
    state_t    state_reg;
    state_t    state_next;

    logic [ADDR_W-1:0]  clr_reg;
    command_t           cmd_reg;
    logic [ADDR_W-1:0]  base_a_reg;
    logic [ADDR_W-1:0]  base_b_reg;
    logic [PIXEL_W-1:0] bin_reg [CHANNELS];
    logic [PIXEL_W-1:0] bin_now [CHANNELS];
    logic [IDX_W-1:0]   off_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [WORD_W-1:0]  size_a_reg;
    logic [WORD_W-1:0]  size_b_reg;
    logic [WORD_W:0]    total_reg;
    logic [DIV_W-1:0]   sum_reg;
    logic [DIV_W-1:0]   acc_reg;
    logic [WORD_W-1:0]  h1_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [SIM_W-1:0]   sim_res_reg;
    logic               err_res_reg;
    logic               out_valid_reg;
    out_item_t          out_item_reg;

    logic               a_ok;
    logic               b_ok;
    logic               accept;
    logic [ADDR_W-1:0]  addr_a;
    logic [ADDR_W-1:0]  addr_b;
    logic [ADDR_W-1:0]  add_addr;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [WORD_W-1:0]  rd_data;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic [WORD_W-1:0]  mul_x;
    logic [WORD_W-1:0]  mul_y;
    logic [2*WORD_W-1:0] mul_out;
    logic [WORD_W-1:0]  bin_min;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    assign in_item = in_ch.payload;
    assign accept  = in_ch.valid && in_ch.ready;
    assign a_ok    = 32'(in_item.region_a) < MAX_REGIONS;
    assign b_ok    = 32'(in_item.region_b) < MAX_REGIONS;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            logic [PIXEL_W-1:0] val;
            val = (c == 0) ? in_item.pixel_red :
                  (c == 1) ? in_item.pixel_green :
                  (c == 2) ? in_item.pixel_blue : '0;
            bin_now[c] = PIXEL_W'((17'(val) * 17'(BINS)) >> 8);
        end
    end

    assign addr_a   = base_a_reg + ADDR_W'(idx_reg);
    assign addr_b   = base_b_reg + ADDR_W'(idx_reg);
    assign add_addr = base_a_reg + ADDR_W'(off_reg) + ADDR_W'(bin_reg[0]);
    assign mul_x    = (state_reg == ST_M_MUL1) ? h1_reg : rd_data;
    assign mul_y    = (state_reg == ST_M_MUL1) ? size_a_reg : size_b_reg;
    assign mul_out  = mul_x * mul_y;
    assign bin_min  = (h1_reg < rd_data) ? h1_reg : rd_data;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = addr_a;
        wr_en   = 1'b0;
        wr_addr = addr_a;
        wr_data = div_rsp.quotient[WORD_W-1:0];
        div_req = '0;
        unique case (state_reg) inside
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
            end
            ST_ADD_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = add_addr;
            end
            ST_ADD_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = add_addr;
                wr_data = (rd_data == WORD_MAX) ? rd_data : rd_data + WORD_W'(1);
            end
            ST_NSUM_RD, ST_NDIV_RD, ST_SIM_RDA, ST_M_RDA:
            begin
                rd_en = 1'b1;
            end
            ST_SIM_RDB, ST_M_RDB:
            begin
                rd_en   = 1'b1;
                rd_addr = addr_b;
            end
            ST_NDIV_LD:
            begin
                div_req.start    = 1'b1;
                div_req.divisor  = sum_reg;
                div_req.rem_init = DIV_W'(rd_data >> 1);
                div_req.bits     = {rd_data[0], {(QUO_W-1){1'b0}}};
                div_req.steps    = NORM_STEPS;
            end
            ST_NDIV_RUN, ST_M_DIV:
            begin
                wr_en = div_rsp.done;
            end
            ST_M_DLD:
            begin
                div_req.start    = 1'b1;
                div_req.divisor  = DIV_W'(total_reg);
                div_req.rem_init = DIV_W'(prod_reg[PROD_W-1:QUO_W]);
                div_req.bits     = prod_reg[QUO_W-1:0];
                div_req.steps    = MERGE_STEPS;
            end
            ST_M_WRB:
            begin
                wr_en   = 1'b1;
                wr_addr = addr_b;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_reg == ADDR_W'(DEPTH - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_ch.valid)
                begin
                    unique case (in_item.command)
                        CMD_ADD:  state_next = a_ok ? ST_ADD_RD : ST_DONE;
                        CMD_NORM: state_next = a_ok ? ST_NSUM_RD : ST_DONE;
                        CMD_SIM:  state_next = (a_ok && b_ok) ? ST_SIM_RDA : ST_DONE;
                        CMD_MERGE:
                            state_next = (a_ok && b_ok && (in_item.size_a != '0 ||
                                          in_item.size_b != '0)) ? ST_M_RDA : ST_DONE;
                        default:  state_next = ST_DONE;
                    endcase
                end
            ST_ADD_RD:   state_next = ST_ADD_WR;
            ST_ADD_WR:   state_next = (off_reg == OFF_LAST) ? ST_DONE : ST_ADD_RD;
            ST_NSUM_RD:  state_next = ST_NSUM_ACC;
            ST_NSUM_ACC: state_next = (idx_reg == IDX_LAST) ? ST_NCHK : ST_NSUM_RD;
            ST_NCHK:     state_next = (sum_reg == '0) ? ST_DONE : ST_NDIV_RD;
            ST_NDIV_RD:  state_next = ST_NDIV_LD;
            ST_NDIV_LD:  state_next = ST_NDIV_RUN;
            ST_NDIV_RUN:
                if (div_rsp.done)
                    state_next = (idx_reg == IDX_LAST) ? ST_DONE : ST_NDIV_RD;
            ST_SIM_RDA:  state_next = ST_SIM_RDB;
            ST_SIM_RDB:  state_next = ST_SIM_ACC;
            ST_SIM_ACC:  state_next = (idx_reg == IDX_LAST) ? ST_SIM_END : ST_SIM_RDA;
            ST_SIM_END:  state_next = ST_DONE;
            ST_M_RDA:    state_next = ST_M_RDB;
            ST_M_RDB:    state_next = ST_M_MUL1;
            ST_M_MUL1:   state_next = ST_M_MUL2;
            ST_M_MUL2:   state_next = ST_M_DLD;
            ST_M_DLD:    state_next = ST_M_DIV;
            ST_M_DIV:
                if (div_rsp.done)
                    state_next = ST_M_WRB;
            ST_M_WRB:    state_next = (idx_reg == IDX_LAST) ? ST_DONE : ST_M_RDA;
            ST_DONE:
                if (!out_valid_reg || out_ch.ready)
                    state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            if (state_reg == ST_DONE && (!out_valid_reg || out_ch.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg) inside
            ST_IDLE:
                if (accept)
                begin
                    cmd_reg     <= in_item.command;
                    base_a_reg  <= ADDR_W'(in_item.region_a * HIST_LEN);
                    base_b_reg  <= ADDR_W'(in_item.region_b * HIST_LEN);
                    for (int c = 0; c < CHANNELS; c++)
                        bin_reg[c] <= bin_now[c];
                    size_a_reg  <= in_item.size_a;
                    size_b_reg  <= in_item.size_b;
                    total_reg   <= (WORD_W+1)'(in_item.size_a) + (WORD_W+1)'(in_item.size_b);
                    off_reg     <= '0;
                    idx_reg     <= '0;
                    sum_reg     <= '0;
                    acc_reg     <= '0;
                    sim_res_reg <= '0;
                    err_res_reg <= (in_item.command == CMD_MERGE) && a_ok && b_ok &&
                                   in_item.size_a == '0 && in_item.size_b == '0;
                end
            ST_ADD_WR:
            begin
                off_reg <= off_reg + OFF_STEP;
                for (int c = 0; c < CHANNELS - 1; c++)
                    bin_reg[c] <= bin_reg[c + 1];
            end
            ST_NSUM_ACC:
            begin
                sum_reg <= sum_reg + DIV_W'(rd_data);
                idx_reg <= (idx_reg == IDX_LAST) ? '0 : idx_reg + IDX_W'(1);
            end
            ST_NCHK:
                err_res_reg <= (sum_reg == '0);
            ST_NDIV_RUN:
                if (div_rsp.done)
                    idx_reg <= idx_reg + IDX_W'(1);
            ST_SIM_RDB, ST_M_RDB:
                h1_reg <= rd_data;
            ST_SIM_ACC:
            begin
                acc_reg <= acc_reg + DIV_W'(bin_min);
                idx_reg <= idx_reg + IDX_W'(1);
            end
            ST_SIM_END:
                sim_res_reg <= (acc_reg > DIV_W'(Q16_ONE)) ? Q16_ONE : acc_reg[SIM_W-1:0];
            ST_M_MUL1:
                prod_reg <= PROD_W'(mul_out);
            ST_M_MUL2:
                prod_reg <= prod_reg + PROD_W'(mul_out);
            ST_M_WRB:
                idx_reg <= idx_reg + IDX_W'(1);
            ST_DONE:
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_item_reg.similarity <= sim_res_reg;
                    out_item_reg.error      <= err_res_reg;
                end
            default:
            begin
            end
        endcase
    end

    assign in_ch.ready    = (state_reg == ST_IDLE);
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_item_reg;

    rch_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rch_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    a_norm_quotient: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NDIV_RUN && div_rsp.done) |->
            (div_rsp.quotient <= QUO_W'(Q16_ONE)))
        else $error("normalized bin exceeds one");

    a_merge_quotient: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_M_DIV && div_rsp.done) |-> (div_rsp.quotient[QUO_W-1] == 1'b0))
        else $error("merged bin exceeds the word range");

    a_error_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |->
            (!out_item_reg.error || cmd_reg == CMD_NORM || cmd_reg == CMD_MERGE))
        else $error("error flag raised by a command that cannot fail");

    a_sim_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (out_item_reg.similarity == '0 || cmd_reg == CMD_SIM))
        else $error("similarity reported for a command other than a query");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> (state_reg == ST_NDIV_LD || state_reg == ST_M_DLD))
        else $error("divider started outside a load step");

endmodule

`default_nettype wire

[tb/sv/region_color_histogram_engine_test.sv]
// Self-checking testbench for the region colour histogram engine.
`timescale 1ns / 100ps

module region_color_histogram_engine_test;
    import rch_pkg::*;

    localparam int REGIONS  = 1024;
    localparam int NBINS    = 25;
    localparam int NCHAN    = 3;
    localparam int HIST_LEN = NBINS * NCHAN;
    localparam int RANDOM_ITEMS = 1700;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rch_stream_if #(.payload_t(in_item_t))  in_ch ();
    rch_stream_if #(.payload_t(out_item_t)) out_ch ();

    region_color_histogram_engine dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #1 clk = ~clk;

    logic [WORD_W-1:0] hist_table [0:REGIONS*HIST_LEN-1];
    out_item_t expected_results [$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles   = 0;
    int mismatch_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int cmd_count [4] = '{0, 0, 0, 0};
    int error_count = 0;

    initial
    begin
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        foreach (hist_table[i])
            hist_table[i] = '0;
    end

    function automatic out_item_t predict_histogram(in_item_t it);
        out_item_t res;
        int base_a;
        int base_b;
        int b;
        logic [63:0] total;
        logic [63:0] acc;
        logic [63:0] mean;
        logic [7:0] pix [3];
        res = '0;
        base_a = int'(it.region_a) * HIST_LEN;
        base_b = int'(it.region_b) * HIST_LEN;
        pix[0] = it.pixel_red;
        pix[1] = it.pixel_green;
        pix[2] = it.pixel_blue;
        case (it.command)
            CMD_ADD:
            begin
                for (int c = 0; c < NCHAN; c++)
                begin
                    b = (int'(pix[c]) * NBINS) / 256;
                    if (hist_table[base_a + c*NBINS + b] != WORD_MAX)
                        hist_table[base_a + c*NBINS + b] += 1'b1;
                end
            end
            CMD_NORM:
            begin
                total = 0;
                for (int i = 0; i < HIST_LEN; i++)
                    total += hist_table[base_a + i];
                if (total == 0)
                    res.error = 1'b1;
                else
                    for (int i = 0; i < HIST_LEN; i++)
                        hist_table[base_a + i] =
                            WORD_W'(({40'd0, hist_table[base_a + i]} << 16) / total);
            end
            CMD_SIM:
            begin
                acc = 0;
                for (int i = 0; i < HIST_LEN; i++)
                    acc += (hist_table[base_a + i] < hist_table[base_b + i]) ?
                           hist_table[base_a + i] : hist_table[base_b + i];
                res.similarity = (acc > 65536) ? Q16_ONE : SIM_W'(acc);
            end
            default:
            begin
                total = {40'd0, it.size_a} + {40'd0, it.size_b};
                if (total == 0)
                    res.error = 1'b1;
                else
                    for (int i = 0; i < HIST_LEN; i++)
                    begin
                        mean = ({40'd0, hist_table[base_a + i]} * it.size_a +
                                {40'd0, hist_table[base_b + i]} * it.size_b) / total;
                        hist_table[base_a + i] = WORD_W'(mean);
                        hist_table[base_b + i] = WORD_W'(mean);
                    end
            end
        endcase
        return res;
    endfunction

    function automatic in_item_t make_item(command_t cmd, int ra, int rb,
                                           int r, int g, int bl, int sa, int sb);
        in_item_t it;
        it.command     = cmd;
        it.region_a    = REGION_W'(ra);
        it.region_b    = REGION_W'(rb);
        it.pixel_red   = PIXEL_W'(r);
        it.pixel_green = PIXEL_W'(g);
        it.pixel_blue  = PIXEL_W'(bl);
        it.size_a      = WORD_W'(sa);
        it.size_b      = WORD_W'(sb);
        return it;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        $display("MISMATCH %s: got %0d, expected %0d (result %0d)",
                 what, got, want, results_checked);
    endtask

    task automatic send_item(in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_results.push_back(predict_histogram(it));
        cmd_count[it.command]++;
        items_sent++;
    endtask

    always @(posedge clk)
    begin
        if (out_ch.valid && out_ch.ready)
        begin
            results_checked++;
            if (expected_results.size() == 0)
                report_mismatch("unexpected item", 1, 0);
            else
            begin
                out_item_t want;
                want = expected_results.pop_front();
                if (want.error)
                    error_count++;
                if (out_ch.payload.similarity !== want.similarity)
                    report_mismatch("similarity", out_ch.payload.similarity,
                                    want.similarity);
                if (out_ch.payload.error !== want.error)
                    report_mismatch("error", out_ch.payload.error, want.error);
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic int pick_region();
        int k;
        k = $urandom_range(19);
        if (k == 0)
            return 1023;
        if (k == 1)
            return $urandom_range(REGIONS - 1);
        return $urandom_range(7);
    endfunction

    function automatic int pick_size();
        int k;
        k = $urandom_range(9);
        if (k == 0)
            return 0;
        if (k == 1)
            return 24'hFFFFFF;
        if (k < 5)
            return $urandom_range(24'hFFFFFF);
        return $urandom_range(1000);
    endfunction

    task automatic test_directed();
        send_item(make_item(CMD_NORM, 5, 0, 0, 0, 0, 0, 0));
        send_item(make_item(CMD_MERGE, 6, 7, 0, 0, 0, 0, 0));
        send_item(make_item(CMD_ADD, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(CMD_ADD, 0, 0, 255, 255, 255, 0, 0));
        send_item(make_item(CMD_ADD, 0, 0, 10, 11, 245, 0, 0));
        send_item(make_item(CMD_ADD, 1023, 0, 255, 0, 128, 0, 0));
        send_item(make_item(CMD_ADD, 1023, 0, 170, 85, 127, 0, 0));
        send_item(make_item(CMD_SIM, 0, 1023, 0, 0, 0, 0, 0));
        send_item(make_item(CMD_SIM, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(CMD_NORM, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(CMD_SIM, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(CMD_NORM, 1023, 0, 0, 0, 0, 0, 0));
        send_item(make_item(CMD_SIM, 1023, 0, 0, 0, 0, 0, 0));
        send_item(make_item(CMD_MERGE, 0, 1023, 0, 0, 0, 0, 0));
        send_item(make_item(CMD_MERGE, 0, 1023, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF));
        send_item(make_item(CMD_MERGE, 0, 1023, 0, 0, 0, 24'hFFFFFF, 0));
        send_item(make_item(CMD_MERGE, 0, 0, 0, 0, 0, 3, 9));
        send_item(make_item(CMD_SIM, 0, 1023, 0, 0, 0, 0, 0));
        send_item(make_item(CMD_ADD, 2, 0, 1, 2, 3, 0, 0));
        send_item(make_item(CMD_MERGE, 2, 1, 0, 0, 0, 0, 5));
        send_item(make_item(CMD_SIM, 2, 1, 0, 0, 0, 0, 0));
    endtask

    task automatic send_random_items(int count);
        int k;
        command_t cmd;
        for (int n = 0; n < count; n++)
        begin
            k = $urandom_range(99);
            cmd = (k < 80) ? CMD_ADD : (k < 87) ? CMD_SIM : (k < 93) ? CMD_NORM : CMD_MERGE;
            send_item(make_item(cmd, pick_region(), pick_region(),
                                $urandom_range(255), $urandom_range(255),
                                $urandom_range(255), pick_size(), pick_size()));
        end
    endtask

    task automatic test_random_traffic();
        send_idle_pct = 36;
        recv_idle_pct = 61;
        send_random_items(RANDOM_ITEMS / 3);
        send_idle_pct = 61;
        recv_idle_pct = 36;
        send_random_items(RANDOM_ITEMS / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_items(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    endtask

    task automatic test_output_stall();
        hold_cycles = 400;
        for (int n = 0; n < 12; n++)
            send_item(make_item(CMD_ADD, $urandom_range(7), 0, $urandom_range(255),
                                $urandom_range(255), $urandom_range(255), 0, 0));
        send_item(make_item(CMD_SIM, 3, 4, 0, 0, 0, 0, 0));
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_output_stall();
        test_random_traffic();
        @(posedge clk);
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Sent %0d items: %0d add, %0d normalize, %0d similarity, %0d merge.",
                 items_sent, cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3]);
        $display("Checked %0d results, %0d with the error flag, %0d mismatches.",
                 results_checked, error_count, mismatch_count);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("Timeout with %0d results outstanding.", expected_results.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
